// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the route-table top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/dvrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dvrt_pkg;

    localparam int IDX_BITS    = 4;
    localparam int ROUTERS     = 1 << IDX_BITS;
    localparam int COST_BITS   = 16;
    localparam int ADDR_BITS   = 2 * IDX_BITS;
    localparam int TABLE_DEPTH = ROUTERS * ROUTERS;
    localparam int CNT_BITS    = $clog2(ROUTERS + 1);

    typedef logic [IDX_BITS-1:0]  router_t;
    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    localparam cost_t INF_COST = COST_BITS'(65535);

    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_VECTOR = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V_DIAG,
        ST_V_WRITE,
        ST_V_RELAX,
        ST_L_SRC,
        ST_L_CHECK,
        ST_L_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        cost_t wr_data;
        logic  clear;
        addr_t diag_addr;
    } tbl_req_t;

    function automatic cost_t clamp_cost(input cost_t c);
        return (c > INF_COST) ? INF_COST : c;
    endfunction

    function automatic cost_t sat_add(input cost_t a, input cost_t b);
        logic [COST_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > {1'b0, INF_COST})
        begin
            return INF_COST;
        end
        return sum[COST_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dvrt_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dvrt_cfg_if
    import dvrt_pkg::*;
();
    logic    valid;
    logic    ready;
    router_t own_router;

    modport source (output valid, output own_router, input ready);
    modport sink (input valid, input own_router, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dvrt_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dvrt_req_if
    import dvrt_pkg::*;
();
    logic    valid;
    logic    ready;
    action_t action;
    router_t peer_router;
    router_t relax_row;
    router_t element_index;
    cost_t   element_cost;
    cost_t   hop_cost;
    logic    last_element;
    router_t lookup_source;
    router_t lookup_target;

    modport source (
        output valid, output action, output peer_router, output relax_row,
        output element_index, output element_cost, output hop_cost,
        output last_element, output lookup_source, output lookup_target,
        input ready
    );
    modport sink (
        input valid, input action, input peer_router, input relax_row,
        input element_index, input element_cost, input hop_cost,
        input last_element, input lookup_source, input lookup_target,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/dvrt_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dvrt_rsp_if
    import dvrt_pkg::*;
();
    logic    valid;
    logic    ready;
    router_t next_hop;
    logic    route_found;
    logic    send_request;
    logic    neighbor_overflow;

    modport source (
        output valid, output next_hop, output route_found, output send_request,
        output neighbor_overflow, input ready
    );
    modport sink (
        input valid, input next_hop, input route_found, input send_request,
        input neighbor_overflow, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/dvrt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dvrt_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvrt_table
    import dvrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_req_t tbl_req,
    output cost_t         rd_data
);

    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [TABLE_DEPTH-1:0] vld_next;
    addr_t                  diag_reg;
    addr_t                  diag_next;
    logic                   rvld_reg;
    addr_t                  raddr_reg;
    cost_t                  ram_q;

    dvrt_ram #(
        .WIDTH(COST_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (tbl_req.wr_en),
        .waddr (tbl_req.wr_addr),
        .wdata (tbl_req.wr_data),
        .raddr (tbl_req.rd_addr),
        .rdata (ram_q)
    );

    // An entry not written since the last initialize reads as infinity,
    // except the own diagonal recorded at that time, which reads as zero.
    always_comb
    begin
        vld_next  = vld_reg;
        diag_next = diag_reg;
        if (tbl_req.clear)
        begin
            vld_next  = '0;
            diag_next = tbl_req.diag_addr;
        end
        else if (tbl_req.wr_en)
        begin
            vld_next[tbl_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            diag_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            diag_reg <= diag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rvld_reg  <= vld_reg[tbl_req.rd_addr];
        raddr_reg <= tbl_req.rd_addr;
    end

    assign rd_data = rvld_reg ? ram_q : ((raddr_reg == diag_reg) ? '0 : INF_COST);

endmodule

`default_nettype wire

// ----- rtl/core/dvrt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire router_t own_router,
    dvrt_req_if.sink     req,
    dvrt_rsp_if.source   rsp,
    output tbl_req_t     tbl_req,
    input  wire cost_t   rd_data
);

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    logic    pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;

    router_t peer_reg, relax_reg, idx_reg, src_reg, tgt_reg;
    cost_t   elem_reg, hop_reg;
    logic    last_reg;
    logic    fwd_reg, fwd_next;
    count_t  issue_reg, issue_next;
    router_t cmp_reg, cmp_next;
    cost_t   best_reg, best_next;
    router_t res_hop_reg, res_hop_next;
    logic    res_found_reg, res_found_next;
    logic    res_send_reg, res_send_next;
    logic    res_ovf_reg, res_ovf_next;

    router_t out_hop_reg;
    logic    out_found_reg, out_send_reg, out_ovf_reg;

    router_t nid_reg [ROUTERS];
    cost_t   ncost_reg [ROUTERS];

    logic    accept;
    logic    nb_we;
    logic    load_out;
    cost_t   entry;
    cost_t   total;
    logic    upd;
    logic    pend_now;
    cost_t   scan_total;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        fwd_next       = fwd_reg;
        issue_next     = issue_reg;
        cmp_next       = cmp_reg;
        best_next      = best_reg;
        res_hop_next   = res_hop_reg;
        res_found_next = res_found_reg;
        res_send_next  = res_send_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        nb_we          = 1'b0;
        load_out       = 1'b0;
        tbl_req        = '0;
        entry          = fwd_reg ? elem_reg : rd_data;
        total          = sat_add(elem_reg, hop_reg);
        upd            = (entry == INF_COST) || (entry > total);
        pend_now       = pend_reg || upd;
        scan_total     = sat_add(rd_data, ncost_reg[cmp_reg]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_hop_next   = '0;
                    res_found_next = 1'b0;
                    res_send_next  = 1'b0;
                    res_ovf_next   = 1'b0;
                    unique case (req.action)
                        ACT_INIT:
                        begin
                            tbl_req.clear     = 1'b1;
                            tbl_req.diag_addr = {own_router, own_router};
                            count_next        = '0;
                            pend_next         = 1'b0;
                            state_next        = ST_DONE;
                        end
                        ACT_ADD:
                        begin
                            if (count_reg == CNT_BITS'(ROUTERS))
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else
                            begin
                                nb_we           = 1'b1;
                                count_next      = count_reg + CNT_BITS'(1);
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = {own_router, req.peer_router};
                                tbl_req.wr_data = clamp_cost(req.hop_cost);
                            end
                            state_next = ST_DONE;
                        end
                        ACT_VECTOR:
                        begin
                            state_next = ST_V_DIAG;
                        end
                        ACT_LOOKUP:
                        begin
                            state_next = ST_L_SRC;
                        end
                    endcase
                end
            end
            ST_V_DIAG:
            begin
                tbl_req.rd_addr = {peer_reg, peer_reg};
                state_next      = ST_V_WRITE;
            end
            ST_V_WRITE:
            begin
                if (rd_data == INF_COST)
                begin
                    pend_next = 1'b1;
                end
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = {peer_reg, idx_reg};
                tbl_req.wr_data = elem_reg;
                // The relaxed entry is the one just written when the rows match.
                tbl_req.rd_addr = {relax_reg, idx_reg};
                fwd_next        = (relax_reg == peer_reg);
                state_next      = ST_V_RELAX;
            end
            ST_V_RELAX:
            begin
                if (upd)
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = {relax_reg, idx_reg};
                    tbl_req.wr_data = total;
                end
                if (last_reg)
                begin
                    res_send_next = pend_now;
                    pend_next     = 1'b0;
                end
                else
                begin
                    pend_next = pend_now;
                end
                state_next = ST_DONE;
            end
            ST_L_SRC:
            begin
                tbl_req.rd_addr = {src_reg, tgt_reg};
                state_next      = ST_L_CHECK;
            end
            ST_L_CHECK:
            begin
                if ((rd_data == INF_COST) || (count_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    tbl_req.rd_addr = {nid_reg[0], tgt_reg};
                    issue_next      = CNT_BITS'(1);
                    cmp_next        = '0;
                    best_next       = INF_COST;
                    state_next      = ST_L_SCAN;
                end
            end
            ST_L_SCAN:
            begin
                if ((rd_data != INF_COST) && (scan_total < best_reg))
                begin
                    best_next      = scan_total;
                    res_hop_next   = nid_reg[cmp_reg];
                    res_found_next = 1'b1;
                end
                tbl_req.rd_addr = {nid_reg[issue_reg[IDX_BITS-1:0]], tgt_reg};
                if ((CNT_BITS'(cmp_reg) + CNT_BITS'(1)) == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmp_next   = issue_reg[IDX_BITS-1:0];
                    issue_next = issue_reg + CNT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            peer_reg  <= req.peer_router;
            relax_reg <= req.relax_row;
            idx_reg   <= req.element_index;
            elem_reg  <= clamp_cost(req.element_cost);
            hop_reg   <= clamp_cost(req.hop_cost);
            last_reg  <= req.last_element;
            src_reg   <= req.lookup_source;
            tgt_reg   <= req.lookup_target;
        end
        if (nb_we)
        begin
            nid_reg[count_reg[IDX_BITS-1:0]]   <= req.peer_router;
            ncost_reg[count_reg[IDX_BITS-1:0]] <= clamp_cost(req.hop_cost);
        end
        if (load_out)
        begin
            out_hop_reg   <= res_hop_reg;
            out_found_reg <= res_found_reg;
            out_send_reg  <= res_send_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
        fwd_reg       <= fwd_next;
        issue_reg     <= issue_next;
        cmp_reg       <= cmp_next;
        best_reg      <= best_next;
        res_hop_reg   <= res_hop_next;
        res_found_reg <= res_found_next;
        res_send_reg  <= res_send_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.next_hop          = out_hop_reg;
    assign rsp.route_found       = out_found_reg;
    assign rsp.send_request      = out_send_reg;
    assign rsp.neighbor_overflow = out_ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/core/distance_vector_route_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Distance-vector route table for one router of up to sixteen. Every item gives
// exactly one result item. The cost table sits in a 256-entry memory with one
// write port and one registered read port, which paces the items. Initialize
// and add-neighbor go straight to the result; a vector element reads the peer
// diagonal, writes, then relaxes; a lookup reads the source entry and, if it
// reaches the target, scans the neighbors. Initialize needs no clearing pass:
// per-entry valid bits make unwritten entries read as infinity at once. The own
// router register may be written only while no item is in flight.
module distance_vector_route_table_core
    import dvrt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dvrt_cfg_if.sink   cfg,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp
);

`include "assert_macros.svh"

    router_t  own_router_reg;
    router_t  own_router_next;
    tbl_req_t tbl_req;
    cost_t    rd_data;

    assign cfg.ready       = 1'b1;
    assign own_router_next = cfg.valid ? cfg.own_router : own_router_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_router_reg <= '0;
        end
        else
        begin
            own_router_reg <= own_router_next;
        end
    end

    dvrt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .own_router (own_router_reg),
        .req        (req),
        .rsp        (rsp),
        .tbl_req    (tbl_req),
        .rd_data    (rd_data)
    );

    dvrt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .tbl_req (tbl_req),
        .rd_data (rd_data)
    );

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `ASSERT_IMPL(a_hop_needs_route, clk, rst_n, rsp.valid && !rsp.route_found, rsp.next_hop == '0)
    `ASSERT_IMPL(a_one_flag, clk, rst_n, rsp.valid, $onehot0({rsp.route_found, rsp.send_request, rsp.neighbor_overflow}))
    `ASSERT_IMPL(a_no_table_clash, clk, rst_n, tbl_req.clear, !tbl_req.wr_en)

endmodule

`default_nettype wire
